[sv/cfc_pkg.sv]
// cfc_pkg: shared types, constants and the crc byte update for the crc16 frame checker
// no dependencies; imported by the interfaces and every module of the block

package cfc_pkg;

   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   localparam logic [1:0] COUNT_ZERO = 2'd0;
   localparam logic [1:0] COUNT_ONE  = 2'd1;
   localparam logic [1:0] COUNT_SAT  = 2'd2;

   // code 3 is unused and treated as plain
   typedef enum logic [1:0] {
      MODE_PLAIN = 2'd0,
      MODE_FOLD  = 2'd1,
      MODE_CHECK = 2'd2
   } frame_mode_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } item_type;

   typedef struct packed {
      logic [15:0] crc_value;
      logic        frame_ok;
      logic        too_short;
   } result_type;

   // reflected crc-16 update over one byte, lsb first
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

[sv/cfc_req_if.sv]
// cfc_req_if: valid/ready channel carrying one frame byte and its first/last marks
// depends on cfc_pkg

interface cfc_req_if
   import cfc_pkg::*;
();
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output first_byte, output last_byte,
                   input ready);
   modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                   output ready);
endinterface

[sv/cfc_rsp_if.sv]
// cfc_rsp_if: valid/ready channel carrying one frame result
// depends on cfc_pkg

interface cfc_rsp_if
   import cfc_pkg::*;
();
   logic        valid;
   logic        ready;
   logic [15:0] crc_value;
   logic        frame_ok;
   logic        too_short;

   modport source (output valid, output crc_value, output frame_ok, output too_short,
                   input ready);
   modport sink   (input valid, input crc_value, input frame_ok, input too_short,
                   output ready);
endinterface

[sv/crc16_frame_checker.sv]
// crc16_frame_checker: frame level crc-16 (reflected, poly 0xa001) checker, one byte a cycle
// result path: a last byte passes the input register, then its result is held in the result register
// throughput: one byte transaction per cycle; the result register stalls only last bytes
// the byte update is an unrolled eight-step crc between the input and result registers
// reset: synchronous, active high; crc state to 0xffff, byte count to zero, mode to plain
// depends on cfc_pkg, cfc_req_if, cfc_rsp_if, cfc_in_stage and cfc_engine

module crc16_frame_checker
   import cfc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   cfc_req_if.sink          req_bus,
   cfc_rsp_if.source        rsp_bus,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_wr_data
);

   // mode register; the user must write it only while no frame is in flight, the block does not enforce this
   frame_mode_type frame_mode_ff;

   logic       in_ready;
   item_type   req_item;
   logic       item_valid;
   item_type   item_q;
   logic       item_take;
   logic       rsp_valid;
   result_type rsp_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_mode_ff <= MODE_PLAIN;
      end else if (csr_wr_en) begin
         frame_mode_ff <= frame_mode_type'(csr_wr_data);
      end
   end

   // gather the incoming transaction into one item
   assign req_item.data_byte  = req_bus.data_byte;
   assign req_item.first_byte = req_bus.first_byte;
   assign req_item.last_byte  = req_bus.last_byte;
   assign req_bus.ready       = in_ready;

   // input register: decouples the request side from the crc logic
   cfc_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_item   (req_item),
      .in_ready  (in_ready),
      .out_valid (item_valid),
      .out_item  (item_q),
      .out_take  (item_take)
   );

   // crc state update and result register
   cfc_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .frame_mode (frame_mode_ff),
      .item_valid (item_valid),
      .item       (item_q),
      .item_take  (item_take),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result),
      .rsp_ready  (rsp_bus.ready)
   );

   // result transaction out
   assign rsp_bus.valid     = rsp_valid;
   assign rsp_bus.crc_value = rsp_result.crc_value;
   assign rsp_bus.frame_ok  = rsp_result.frame_ok;
   assign rsp_bus.too_short = rsp_result.too_short;

`ifndef SYNTH
   // a short check frame carries no crc and never passes
   a_short_frame_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result.too_short |-> rsp_result.crc_value == 16'h0000 &&
                                            !rsp_result.frame_ok)
      else $error("short frame result carries crc or pass flag");

   // with the result register free a held byte always moves on
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      item_valid && !rsp_valid |-> item_take)
      else $error("held byte stalled while result register empty");

   // a new result only follows a last byte leaving the input register
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid) |-> $past(item_take && item_q.last_byte))
      else $error("result appeared without a last byte");
`endif

endmodule

[sv/cfc_in_stage.sv]
// cfc_in_stage: input register holding one accepted byte transaction
// depends on cfc_pkg

module cfc_in_stage
   import cfc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  item_type in_item,
   output logic     in_ready,
   output logic     out_valid,
   output item_type out_item,
   input  logic     out_take
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   // refill in the same cycle the held item moves on
   assign in_ready = !valid_ff || out_take;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

[sv/cfc_engine.sv]
// cfc_engine: crc state, per-byte update and the registered frame result
// depends on cfc_pkg (crc16_byte, item and result types)

module cfc_engine
   import cfc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  frame_mode_type frame_mode,
   input  logic           item_valid,
   input  item_type       item,
   output logic           item_take,
   output logic           rsp_valid,
   output result_type     rsp_result,
   input  logic           rsp_ready
);

   logic [15:0] running_crc_ff;
   logic [15:0] running_crc_in;
   logic [15:0] crc_before_prev_ff;
   logic [7:0]  prev_byte_ff;
   logic [1:0]  byte_count_ff;
   logic [1:0]  byte_count_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   result_type  rsp_result_ff;

   logic [15:0] crc_start;
   logic [1:0]  count_start;
   logic [15:0] crc_new;
   result_type  result;

   assign crc_start   = item.first_byte ? CRC_INIT : running_crc_ff;
   assign count_start = item.first_byte ? COUNT_ZERO : byte_count_ff;
   assign crc_new     = crc16_byte(crc_start, item.data_byte);

   // a body byte always moves on; a last byte needs room in the result register
   assign item_take = item_valid && (!item.last_byte || !rsp_valid_ff || rsp_ready);

   always_comb begin
      result.crc_value = crc_new;
      result.frame_ok  = 1'b0;
      result.too_short = 1'b0;
      case (frame_mode)
         MODE_FOLD: begin
            result.crc_value = crc_new + {8'h00, crc_new[15:8]};
         end
         MODE_CHECK: begin
            if (count_start == COUNT_ZERO) begin
               result.crc_value = 16'h0000;
               result.too_short = 1'b1;
            end else begin
               result.crc_value = crc_before_prev_ff;
               result.frame_ok  = (crc_before_prev_ff[7:0] == prev_byte_ff) &&
                                  (crc_before_prev_ff[15:8] == item.data_byte);
            end
         end
         default: begin
            result.crc_value = crc_new;
         end
      endcase
   end

   always_comb begin
      running_crc_in = running_crc_ff;
      byte_count_in  = byte_count_ff;
      if (item_take) begin
         if (item.last_byte) begin
            running_crc_in = CRC_INIT;
            byte_count_in  = COUNT_ZERO;
         end else begin
            running_crc_in = crc_new;
            byte_count_in  = (count_start == COUNT_SAT) ? COUNT_SAT : count_start + COUNT_ONE;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (item_take && item.last_byte) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_crc_ff     <= CRC_INIT;
         crc_before_prev_ff <= CRC_INIT;
         prev_byte_ff       <= 8'h00;
         byte_count_ff      <= COUNT_ZERO;
         rsp_valid_ff       <= 1'b0;
      end else begin
         running_crc_ff <= running_crc_in;
         byte_count_ff  <= byte_count_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (item_take) begin
            crc_before_prev_ff <= crc_start;
            prev_byte_ff       <= item.data_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_take && item.last_byte) begin
         rsp_result_ff <= result;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

endmodule
